// ===== hdl/slpg_pkg.sv =====
// shared types, codes and constants of the status led pattern generator
package slpg_pkg;

	// remainder width: largest divisor is 15*270+900 = 4950
	localparam int DIV_W = 13;
	localparam int PHASE_W = 32;
	localparam int STEP_W = 10;
	localparam int CNT_W = $clog2(PHASE_W);
	localparam int FAULT_W = 4;
	localparam int MODE_W = 3;

	typedef logic [DIV_W-1:0] div_t;
	typedef logic [PHASE_W-1:0] phase_t;

	localparam logic [FAULT_W-1:0] MAX_FAULT_BLINKS = FAULT_W'(15);

	localparam logic [MODE_W-1:0] MODE_OFF = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CONNECTED = 3'd2;
	localparam logic [MODE_W-1:0] MODE_UPDATE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CONFIG = 3'd4;

	// pattern timing in ms
	localparam phase_t FLASH_WINDOW = PHASE_W'(360);
	localparam div_t FLASH_SLOT = DIV_W'(120);
	localparam div_t BLINK_SLOT = DIV_W'(270);
	localparam div_t BLINK_ON = DIV_W'(120);
	localparam div_t FAULT_GAP = DIV_W'(900);
	localparam div_t SEARCH_PERIOD = DIV_W'(2000);
	localparam div_t SEARCH_ON = DIV_W'(150);
	localparam div_t UPDATE_PERIOD = DIV_W'(140);
	localparam div_t UPDATE_ON = DIV_W'(70);
	localparam div_t CONFIG_PERIOD = DIV_W'(1800);
	localparam div_t CONFIG_ON = DIV_W'(120);
	localparam div_t CONFIG_SECOND = DIV_W'(240);
	localparam div_t CONFIG_END = DIV_W'(360);

	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(40);

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_SET_STATUS = 2'd1,
		CMD_SET_FAULT = 2'd2,
		CMD_FLASH = 2'd3
	} cmd_e;

	typedef enum logic [0:0] {
		CFG_TICK_STEP = 1'b0,
		CFG_ACTIVE_LOW = 1'b1
	} cfg_idx_e;

	// which pattern drives the current tick
	typedef enum logic [1:0] {
		SRC_FLASH = 2'd0,
		SRC_FAULT = 2'd1,
		SRC_MODE = 2'd2,
		SRC_CONST = 2'd3
	} src_e;

	typedef enum logic [2:0] {
		S_IDLE = 3'd0,
		S_SEL = 3'd1,
		S_DIV1 = 3'd2,
		S_DIV2 = 3'd3,
		S_FIN = 3'd4
	} state_e;

	typedef struct packed {
		logic take;
		logic select;
		logic start2;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		src_e src;
		logic is_fault;
		logic div_done;
		logic out_free;
	} dp_stat_t;

	typedef struct packed {
		logic valid;
		cfg_idx_e index;
		logic [STEP_W-1:0] data;
	} cfg_wr_t;

endpackage

// ===== hdl/slpg_in_if.sv =====
// input command channel
interface slpg_in_if import slpg_pkg::*; ();
	logic valid;
	logic ready;
	cmd_e command;
	logic [MODE_W-1:0] status_mode;
	logic [FAULT_W-1:0] fault_blinks;

	modport source (output valid, output command, output status_mode, output fault_blinks,
		input ready);
	modport sink (input valid, input command, input status_mode, input fault_blinks,
		output ready);
endinterface

// ===== hdl/slpg_out_if.sv =====
// led level result channel
interface slpg_out_if import slpg_pkg::*; ();
	logic valid;
	logic ready;
	logic led_level;

	modport source (output valid, output led_level, input ready);
	modport sink (input valid, input led_level, output ready);
endinterface

// ===== hdl/slpg_cfg_if.sv =====
// configuration write channel
interface slpg_cfg_if import slpg_pkg::*; ();
	logic valid;
	logic ready;
	cfg_idx_e index;
	logic [STEP_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/slpg_div.sv =====
// serial restoring divider, one quotient bit per cycle
module slpg_div import slpg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input phase_t dividend,
	input div_t divisor,
	output div_t rem,
	output logic q_lsb,
	output logic done
);

	phase_t num_q;
	div_t den_q;
	div_t rem_q;
	logic q_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [DIV_W:0] partial;
	logic [DIV_W:0] diff;
	logic ge;

	assign partial = {rem_q, num_q[PHASE_W-1]};
	assign ge = partial >= {1'b0, den_q};
	assign diff = partial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(PHASE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[PHASE_W-2:0], 1'b0};
			rem_q <= ge ? diff[DIV_W-1:0] : partial[DIV_W-1:0];
			q_q <= ge;
		end
	end

	assign rem = rem_q;
	assign q_lsb = q_q;
	assign done = done_q;

endmodule

// ===== hdl/slpg_dp.sv =====
// datapath: pattern state, config registers, divider and output register
module slpg_dp import slpg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input ctrl_cmd_t cmd,
	output dp_stat_t stat,
	input cmd_e command,
	input logic [MODE_W-1:0] status_mode,
	input logic [FAULT_W-1:0] fault_blinks,
	input cfg_wr_t cfg_wr,
	input logic out_ready,
	output logic out_valid,
	output logic led_level
);

	phase_t phase_q;
	phase_t flash_end_q;
	logic flash_pending_q;
	logic [MODE_W-1:0] mode_q;
	logic [FAULT_W-1:0] fault_q;
	logic [STEP_W-1:0] step_q;
	logic active_low_q;
	src_e src_q;
	logic burst_ok_q;
	logic led_q;
	logic out_valid_q;

	src_e src_sel;
	div_t burst;
	div_t sel_div;
	logic div_start;
	phase_t div_dividend;
	div_t div_divisor;
	div_t rem;
	logic q_lsb;
	logic div_done;
	logic on;
	logic out_free;

	assign burst = div_t'(fault_q) * BLINK_SLOT;

	always_comb begin
		if (phase_q < flash_end_q) begin
			src_sel = SRC_FLASH;
		end else if (fault_q != '0) begin
			src_sel = SRC_FAULT;
		end else if (mode_q inside {MODE_SEARCH, MODE_UPDATE, MODE_CONFIG}) begin
			src_sel = SRC_MODE;
		end else begin
			src_sel = SRC_CONST;
		end
	end

	always_comb begin
		case (src_sel)
			SRC_FLASH: sel_div = FLASH_SLOT;
			SRC_FAULT: sel_div = burst + FAULT_GAP;
			SRC_MODE: begin
				case (mode_q)
					MODE_UPDATE: sel_div = UPDATE_PERIOD;
					MODE_CONFIG: sel_div = CONFIG_PERIOD;
					default: sel_div = SEARCH_PERIOD;
				endcase
			end
			default: sel_div = SEARCH_PERIOD;
		endcase
	end

	// second pass reduces the fault phase by the blink slot
	assign div_start = (cmd.select && src_sel != SRC_CONST) || cmd.start2;
	assign div_dividend = cmd.start2 ? PHASE_W'(rem) : phase_q;
	assign div_divisor = cmd.start2 ? BLINK_SLOT : sel_div;

	slpg_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.rem(rem),
		.q_lsb(q_lsb),
		.done(div_done)
	);

	always_comb begin
		case (src_q)
			SRC_FLASH: on = !q_lsb;
			SRC_FAULT: on = burst_ok_q && (rem < BLINK_ON);
			SRC_MODE: begin
				case (mode_q)
					MODE_SEARCH: on = rem < SEARCH_ON;
					MODE_UPDATE: on = rem < UPDATE_ON;
					MODE_CONFIG: on = (rem < CONFIG_ON) ||
						(rem >= CONFIG_SECOND && rem < CONFIG_END);
					default: on = 1'b0;
				endcase
			end
			default: on = (mode_q == MODE_CONNECTED);
		endcase
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			flash_end_q <= '0;
			flash_pending_q <= 1'b0;
			mode_q <= MODE_SEARCH;
			fault_q <= '0;
			step_q <= STEP_RESET;
			active_low_q <= 1'b0;
			src_q <= SRC_CONST;
			burst_ok_q <= 1'b0;
			led_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr.valid) begin
				case (cfg_wr.index)
					CFG_TICK_STEP: step_q <= cfg_wr.data;
					CFG_ACTIVE_LOW: active_low_q <= cfg_wr.data[0];
					default: ;
				endcase
			end
			if (cmd.take) begin
				case (command)
					CMD_TICK: begin
						if (flash_pending_q) begin
							flash_pending_q <= 1'b0;
							flash_end_q <= phase_q + FLASH_WINDOW;
						end
					end
					CMD_SET_STATUS: begin
						if (fault_q == '0) mode_q <= status_mode;
					end
					CMD_SET_FAULT: begin
						fault_q <= (fault_blinks > MAX_FAULT_BLINKS) ? MAX_FAULT_BLINKS
							: fault_blinks;
					end
					default: flash_pending_q <= 1'b1;
				endcase
			end
			if (cmd.select) src_q <= src_sel;
			if (cmd.start2) burst_ok_q <= rem < burst;
			if (cmd.finish) begin
				led_q <= on ^ active_low_q;
				out_valid_q <= 1'b1;
				phase_q <= phase_q + PHASE_W'(step_q);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.src = src_sel;
	assign stat.is_fault = (src_q == SRC_FAULT);
	assign stat.div_done = div_done;
	assign stat.out_free = out_free;
	assign out_valid = out_valid_q;
	assign led_level = led_q;

endmodule

// ===== hdl/slpg_ctrl.sv =====
// controller: sequences command intake, divider passes and result hand-off
module slpg_ctrl import slpg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input cmd_e command,
	input dp_stat_t stat,
	output logic in_ready,
	output ctrl_cmd_t cmd
);

	state_e state_q;
	state_e state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && command == CMD_TICK) state_d = S_SEL;
			end
			S_SEL: begin
				state_d = (stat.src == SRC_CONST) ? S_FIN : S_DIV1;
			end
			S_DIV1: begin
				if (stat.div_done) state_d = stat.is_fault ? S_DIV2 : S_FIN;
			end
			S_DIV2: begin
				if (stat.div_done) state_d = S_FIN;
			end
			S_FIN: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			S_SEL: cmd.select = 1'b1;
			S_DIV1: cmd.start2 = stat.div_done && stat.is_fault;
			S_FIN: cmd.finish = stat.out_free;
			default: ;
		endcase
	end

endmodule

// ===== hdl/status_led_pattern_generator.sv =====
// top level of the status led pattern generator
//
// channel  | dir | word contents
// ---------+-----+-------------------------------------------
// item     | in  | command, status_mode, fault_blinks
// result   | out | led_level (one word per tick command)
// cfg      | in  | index (0 tick_step_ms, 1 active_low), data
//
// non-tick commands are handled while idle; a tick goes through the shared
// one-bit-per-cycle remainder divider (32 steps), again with a fault code active
// (second pass for the blink slot), and not in connected, off or unknown mode
// reset is asynchronous and puts the phase at 0 with mode searching
// the result register frees the divider: a tick only waits in its last state
// while the previous level has not been taken
// cfg writes are always taken, one per cycle
module status_led_pattern_generator import slpg_pkg::*; (
	input logic clk,
	input logic arst_n,
	slpg_in_if.sink item,
	slpg_out_if.source result,
	slpg_cfg_if.sink cfg
);

	ctrl_cmd_t cmd;
	dp_stat_t stat;
	cfg_wr_t cfg_wr;

	// config writes land straight in the datapath registers
	assign cfg.ready = 1'b1;
	assign cfg_wr.valid = cfg.valid;
	assign cfg_wr.index = cfg.index;
	assign cfg_wr.data = cfg.data;

	// sequencing of intake, divider passes and result load
	slpg_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(item.valid),
		.command(item.command),
		.stat(stat),
		.in_ready(item.ready),
		.cmd(cmd)
	);

	// pattern state, divider and output register
	slpg_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.command(item.command),
		.status_mode(item.status_mode),
		.fault_blinks(item.fault_blinks),
		.cfg_wr(cfg_wr),
		.out_ready(result.ready),
		.out_valid(result.valid),
		.led_level(result.led_level)
	);

	// a tick word keeps the block busy in the following cycle
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready && item.command == CMD_TICK |=> !item.ready)
		else $error("input taken right after a tick");

	// commands other than tick never raise a result word
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready && item.command != CMD_TICK && !result.valid
		|=> !result.valid)
		else $error("result word raised by a non-tick command");

	// a result word only appears after the tick work has run
	a_result_late: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready && item.command == CMD_TICK |=> !$rose(result.valid))
		else $error("result word raised too early");

endmodule

// ===== tb/slpg_level_checker.sv =====
// predicts the led level of every tick word and compares it with the result channel
`timescale 1ns / 100ps

module slpg_level_checker import slpg_pkg::*; (
	input logic clk,
	input logic arst_n,
	slpg_in_if item,
	slpg_out_if result,
	slpg_cfg_if cfg,
	output int unsigned fail_count,
	output int unsigned levels_due
);

	// pattern timing in ms
	localparam phase_t FLASH_WINDOW_MS = 360;
	localparam phase_t FLASH_SLOT_MS = 120;
	localparam phase_t BLINK_SLOT_MS = 270;
	localparam phase_t BLINK_ON_MS = 120;
	localparam phase_t FAULT_GAP_MS = 900;
	localparam phase_t SEARCH_PERIOD_MS = 2000;
	localparam phase_t SEARCH_ON_MS = 150;
	localparam phase_t UPDATE_PERIOD_MS = 140;
	localparam phase_t UPDATE_ON_MS = 70;
	localparam phase_t CONFIG_PERIOD_MS = 1800;
	localparam phase_t CONFIG_FIRST_END_MS = 120;
	localparam phase_t CONFIG_SECOND_MS = 240;
	localparam phase_t CONFIG_SECOND_END_MS = 360;
	localparam logic [STEP_W-1:0] STEP_AFTER_RESET = STEP_W'(40);
	localparam logic [FAULT_W-1:0] FAULT_LIMIT = FAULT_W'(15);

	phase_t phase;
	phase_t flash_end;
	logic flash_due;
	logic [MODE_W-1:0] shown_mode;
	logic [FAULT_W-1:0] fault_cnt;
	logic [STEP_W-1:0] tick_step;
	logic pin_inverted;

	logic led_due[$];
	logic want;
	int unsigned fail_tally = 0;

	assign fail_count = fail_tally;

	task automatic report(input string what);
		fail_tally++;
		$display("%0t ns: mismatch: %s", $time, what);
	endtask

	// level before polarity for one phase value
	function automatic logic pattern_level(input phase_t p);
		phase_t burst;
		phase_t t;
		if (p < flash_end)
			return ((p / FLASH_SLOT_MS) % 2) == 0;
		if (fault_cnt != '0) begin
			burst = phase_t'(fault_cnt) * BLINK_SLOT_MS;
			t = p % (burst + FAULT_GAP_MS);
			return (t < burst) && ((t % BLINK_SLOT_MS) < BLINK_ON_MS);
		end
		case (shown_mode)
		MODE_SEARCH: return (p % SEARCH_PERIOD_MS) < SEARCH_ON_MS;
		MODE_CONNECTED: return 1'b1;
		MODE_UPDATE: return (p % UPDATE_PERIOD_MS) < UPDATE_ON_MS;
		MODE_CONFIG: begin
			t = p % CONFIG_PERIOD_MS;
			return (t < CONFIG_FIRST_END_MS) ||
				(t >= CONFIG_SECOND_MS && t < CONFIG_SECOND_END_MS);
		end
		default: return 1'b0;
		endcase
	endfunction

	task automatic apply_command(input cmd_e c, input logic [MODE_W-1:0] m,
		input logic [FAULT_W-1:0] b);
		case (c)
		CMD_TICK: begin
			if (flash_due) begin
				flash_due = 1'b0;
				flash_end = phase + FLASH_WINDOW_MS;
			end
			led_due.push_back(pattern_level(phase) ^ pin_inverted);
			phase = phase + phase_t'(tick_step);
		end
		CMD_SET_STATUS: if (fault_cnt == '0) shown_mode = m;
		CMD_SET_FAULT: fault_cnt = (b > FAULT_LIMIT) ? FAULT_LIMIT : b;
		default: flash_due = 1'b1;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = '0;
			flash_end = '0;
			flash_due = 1'b0;
			shown_mode = MODE_SEARCH;
			fault_cnt = '0;
			tick_step = STEP_AFTER_RESET;
			pin_inverted = 1'b0;
			led_due.delete();
			levels_due <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				CFG_TICK_STEP: tick_step = cfg.data;
				default: pin_inverted = cfg.data[0];
				endcase
			end
			// results first: a word taken in this cycle belongs to an older tick
			if (result.valid && result.ready) begin
				if (led_due.size() == 0) begin
					report($sformatf("led_level word %0b with no tick waiting",
						result.led_level));
				end else begin
					want = led_due.pop_front();
					if (result.led_level !== want)
						report($sformatf("led_level %0b, predicted %0b",
							result.led_level, want));
				end
			end
			if (item.valid && item.ready)
				apply_command(item.command, item.status_mode, item.fault_blinks);
			levels_due <= led_due.size();
		end
	end

endmodule

// ===== tb/tb_status_led_pattern_generator.sv =====
// stimulus, handshake idling and verdict for the status led pattern generator
`timescale 1ns / 100ps

module tb_status_led_pattern_generator import slpg_pkg::*; ();

	// random part: phases of this many command words each
	localparam int PHASES = 10;
	localparam int WORDS_PER_PHASE = 65;
	// settle pause, well past the run of a tick with a fault code
	localparam int SETTLE_CYCLES = 100;
	// longest quiet stretch of a correct run is the settle pause plus a slow
	// tick behind a long receiver stall, so this is several times that
	localparam int WATCHDOG_LIMIT = 4000;

	typedef enum int {
		SINK_OPEN,
		SINK_COIN,
		SINK_TIGHT,
		SINK_PERIODIC
	} sink_style_e;

	logic clk;
	logic arst_n;
	int unsigned fail_count;
	int unsigned levels_due;
	int unsigned idle_cycles = 0;

	slpg_in_if item_ch();
	slpg_out_if result_ch();
	slpg_cfg_if cfg_ch();

	status_led_pattern_generator uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	// predicts and compares on its own, hands back the failure count
	slpg_level_checker level_check (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg(cfg_ch),
		.fail_count(fail_count),
		.levels_due(levels_due)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// one command word, held until the block takes it; valid stays high on return
	task automatic send_word(input cmd_e c, input logic [MODE_W-1:0] m,
		input logic [FAULT_W-1:0] b);
		item_ch.valid <= 1'b1;
		item_ch.command <= c;
		item_ch.status_mode <= m;
		item_ch.fault_blinks <= b;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
	endtask

	// mostly ticks so the patterns get rendered; fault writes clear half the time
	task automatic send_random();
		int pick;
		cmd_e c;
		logic [MODE_W-1:0] m;
		logic [FAULT_W-1:0] b;
		pick = $urandom_range(0, 99);
		m = MODE_W'($urandom_range(0, 7));
		b = FAULT_W'($urandom_range(0, 15));
		if (pick < 58) begin
			c = CMD_TICK;
		end else if (pick < 74) begin
			c = CMD_SET_STATUS;
		end else if (pick < 88) begin
			c = CMD_SET_FAULT;
			if ($urandom_range(0, 1) == 0) b = '0;
		end else begin
			c = CMD_FLASH;
		end
		send_word(c, m, b);
	endtask

	// bursts of words with gaps between them; steady phases never pause
	task automatic run_random(input int count, input logic steady);
		int left;
		int burst;
		int gap;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 16);
			while (burst > 0 && left > 0) begin
				send_random();
				burst--;
				left--;
			end
			gap = steady ? 0 : $urandom_range(0, 8);
			if (left > 0 && gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// drop valid, let every predicted level come out, then let a trailing
	// non-tick word finish before the registers change
	task automatic settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (levels_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [STEP_W-1:0] step, input logic inverted);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= CFG_TICK_STEP;
		cfg_ch.data <= step;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.index <= CFG_ACTIVE_LOW;
		cfg_ch.data <= STEP_W'(inverted);
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// step of each random phase: 1, 1000, zero step, top of the field, 40, 7, then random
	function automatic logic [STEP_W-1:0] step_for_phase(input int ph);
		case (ph)
		0: return STEP_W'(1);
		1: return STEP_W'(1000);
		2: return STEP_W'(0);
		3: return STEP_W'(1023);
		4: return STEP_W'(40);
		5: return STEP_W'(7);
		default: return STEP_W'($urandom_range(1, 1023));
		endcase
	endfunction

	// directed opening at reset settings (step 40, active high)
	task automatic run_directed();
		send_word(CMD_TICK, 3'd7, 4'd15);          // searching, inside the on slot
		send_word(CMD_TICK, 3'd0, 4'd0);
		send_word(CMD_SET_STATUS, MODE_CONNECTED, 4'd15);
		send_word(CMD_TICK, 3'd0, 4'd0);
		send_word(CMD_SET_STATUS, MODE_UPDATE, 4'd0);
		send_word(CMD_TICK, 3'd0, 4'd0);
		send_word(CMD_TICK, 3'd0, 4'd0);
		send_word(CMD_SET_STATUS, MODE_CONFIG, 4'd0);
		send_word(CMD_TICK, 3'd0, 4'd0);
		// unknown mode codes are kept and show as off
		send_word(CMD_SET_STATUS, 3'd7, 4'd0);
		send_word(CMD_TICK, 3'd0, 4'd0);
		send_word(CMD_SET_STATUS, MODE_OFF, 4'd0);
		// flash arms on the next tick and wins over the mode
		send_word(CMD_FLASH, 3'd0, 4'd0);
		send_word(CMD_TICK, 3'd0, 4'd0);
		send_word(CMD_TICK, 3'd0, 4'd0);
		send_word(CMD_TICK, 3'd0, 4'd0);
		// largest fault code, status change ignored while it stands
		send_word(CMD_SET_FAULT, 3'd0, 4'd15);
		send_word(CMD_SET_STATUS, MODE_CONNECTED, 4'd0);
		send_word(CMD_TICK, 3'd0, 4'd0);
		send_word(CMD_SET_FAULT, 3'd0, 4'd1);
		send_word(CMD_TICK, 3'd0, 4'd0);
		// clearing the fault lets the status through again
		send_word(CMD_SET_FAULT, 3'd7, 4'd0);
		send_word(CMD_SET_STATUS, 3'd5, 4'd0);
		send_word(CMD_FLASH, 3'd0, 4'd0);
		send_word(CMD_TICK, 3'd0, 4'd0);
	endtask

	// receiver stalls on a pattern of its own, switching style now and then
	initial begin : sink_pattern
		int hold;
		sink_style_e style;
		hold = 0;
		style = SINK_OPEN;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold == 0) begin
				style = sink_style_e'($urandom_range(0, 3));
				hold = $urandom_range(16, 160);
			end
			hold--;
			case (style)
			SINK_OPEN: result_ch.ready <= 1'b1;
			SINK_COIN: result_ch.ready <= 1'($urandom_range(0, 1));
			SINK_TIGHT: result_ch.ready <= ($urandom_range(0, 3) == 0);
			default: result_ch.ready <= ((hold % 8) < 5);
			endcase
		end
	end

	initial begin : stimulus
		int ph;
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.command <= CMD_TICK;
		item_ch.status_mode <= '0;
		item_ch.fault_blinks <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_TICK_STEP;
		cfg_ch.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		// every phase rewrites both registers, polarity alternating
		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			configure(step_for_phase(ph), 1'(ph % 2));
			run_random(WORDS_PER_PHASE, $urandom_range(0, 3) == 0);
		end

		// drain, then a quiet stretch to catch stray level words
		settle();

		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// a hung handshake or a missing level word ends the run here
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule
